// File: rtl/core/dnmm_pkg.sv
`timescale 1ns / 1ps

package dnmm_pkg;

  // Frame limits and derived field widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int WIN_SIZE   = 9;

  // Configuration register widths and codes
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd1024;
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_LIMIT  = WIDTH_CFG_W'(MAX_WIDTH);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_LIMIT = HEIGHT_CFG_W'(MAX_HEIGHT);

  localparam logic MODE_MEAN   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  // Divide by nine: sum * 7282 >> 16 is exact for sums up to 9 * 255
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 13;
  localparam int MEAN_SHIFT = 16;
  localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

  // Output bus layout
  localparam int TDATA_W = 32;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_t;

endpackage

// File: rtl/core/denoise_3x3_mean_median.sv
`timescale 1ns / 1ps

// Channel   Dir  Transaction            Payload
// s_axis    in   tvalid & tready        tdata[7:0] pixel_in
// m_axis    out  tvalid & tready        tdata: filtered_pixel, out_row, out_col; tlast
// cfg       in   cfg_wr_en              cfg_index selects register, cfg_wr_data value
//
// One pixel is taken per clock while m_axis is not stalled and each pixel yields at
// most one result; the single result unit emits one result per clock, so a pixel that
// yields two or four results holds the input until its last result is emitted. Reset
// clears counters and pipeline and sets configuration to its defaults; the line buffer
// is not cleared and needs no clearing pass. Stalls on m_axis propagate back through
// the pipeline to s_axis_tready.

module denoise_3x3_mean_median (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dnmm_pkg::PIX_W-1:0]          s_axis_tdata,   // [7:0] pixel_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] filtered_pixel, [19:8] out_row, [29:20] out_col, [31:30] zero
  output logic [dnmm_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic                                m_axis_tlast,   // last_of_run
  input  logic                                cfg_wr_en,
  input  logic [dnmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dnmm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  localparam int COL_W = dnmm_pkg::COL_W;
  localparam int ROW_W = dnmm_pkg::ROW_W;
  localparam int PIX_W = dnmm_pkg::PIX_W;
  localparam int LB_W  = 2 * PIX_W;

  // ---------------------------------------------------------------------------
  // Helpers for the median network
  // ---------------------------------------------------------------------------
  function automatic dnmm_pkg::pixel_t min2(input dnmm_pkg::pixel_t a, input dnmm_pkg::pixel_t b);
    min2 = (a < b) ? a : b;
  endfunction

  function automatic dnmm_pkg::pixel_t max2(input dnmm_pkg::pixel_t a, input dnmm_pkg::pixel_t b);
    max2 = (a < b) ? b : a;
  endfunction

  function automatic dnmm_pkg::pixel_t med3(input dnmm_pkg::pixel_t a, input dnmm_pkg::pixel_t b,
                                            input dnmm_pkg::pixel_t c);
    med3 = max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                                 filter_mode;
  logic [dnmm_pkg::WIDTH_CFG_W-1:0]     image_width;
  logic [dnmm_pkg::HEIGHT_CFG_W-1:0]    image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= dnmm_pkg::MODE_MEAN;
      image_width  <= dnmm_pkg::WIDTH_RESET;
      image_height <= dnmm_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dnmm_pkg::CFG_FILTER_MODE:  filter_mode  <= cfg_wr_data[0];
        dnmm_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_wr_data[dnmm_pkg::WIDTH_CFG_W-1:0];
        dnmm_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Clamp width and height into their legal ranges
  logic [dnmm_pkg::WIDTH_CFG_W-1:0]  width_eff;
  logic [dnmm_pkg::HEIGHT_CFG_W-1:0] height_eff;

  always_comb begin
    if (image_width == '0) begin
      width_eff = dnmm_pkg::WIDTH_CFG_W'(1);
    end else if (image_width > dnmm_pkg::WIDTH_LIMIT) begin
      width_eff = dnmm_pkg::WIDTH_LIMIT;
    end else begin
      width_eff = image_width;
    end
    if (image_height == '0) begin
      height_eff = dnmm_pkg::HEIGHT_CFG_W'(1);
    end else if (image_height > dnmm_pkg::HEIGHT_LIMIT) begin
      height_eff = dnmm_pkg::HEIGHT_LIMIT;
    end else begin
      height_eff = image_height;
    end
  end

  // ---------------------------------------------------------------------------
  // Input acceptance and raster counters
  // ---------------------------------------------------------------------------
  logic             accept;
  logic             s1_adv;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic             row_end_in;
  logic             last_row_in;

  assign accept = s_axis_tvalid && s_axis_tready;

  assign row_end_in  = ({1'b0, col_count} + dnmm_pkg::WIDTH_CFG_W'(1)) >= width_eff;
  assign last_row_in = ({1'b0, row_count} + dnmm_pkg::HEIGHT_CFG_W'(1)) >= height_eff;

  // Advance column and row at each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end_in) begin
        col_count <= '0;
        row_count <= last_row_in ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register, line buffer read data
  // ---------------------------------------------------------------------------
  logic                s1_valid;
  dnmm_pkg::pixel_t    s1_pixel;
  logic [COL_W-1:0]    s1_c;
  logic [ROW_W-1:0]    s1_r;
  logic                s1_row_end;
  logic                s1_last_row;

  logic [LB_W-1:0]     lb_rdata;
  logic [LB_W-1:0]     lb_wdata;
  logic [LB_W-1:0]     fwd_data;
  logic                fwd_flag;
  dnmm_pkg::pixel_t    s1_above;
  dnmm_pkg::pixel_t    s1_two_above;

  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= s_axis_tdata;
      s1_c        <= col_count;
      s1_r        <= row_count;
      s1_row_end  <= row_end_in;
      s1_last_row <= last_row_in;
    end
  end

  // Bypass the line buffer when the column just read is written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_flag <= 1'b0;
    end else if (accept) begin
      fwd_flag <= s1_adv && (s1_c == col_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= lb_wdata;
    end
  end

  assign {s1_two_above, s1_above} = fwd_flag ? fwd_data : lb_rdata;

  // Entry holds {row r-2, row r-1}; the row above moves down, the new pixel enters
  assign lb_wdata = {s1_above, s1_pixel};

  dnmm_ram #(
    .WIDTH (LB_W),
    .DEPTH (dnmm_pkg::MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c),
    .wdata (lb_wdata),
    .re    (accept),
    .raddr (col_count),
    .rdata (lb_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: window registers and result sequencer
  // ---------------------------------------------------------------------------
  dnmm_pkg::window_t   window_regs;
  logic [3:0]          pending;
  logic [ROW_W-1:0]    s2_r;
  logic [COL_W-1:0]    s2_c;
  logic                s2_r_ge1;
  logic                s2_r_ge2;
  logic                s2_c_ge1;
  logic                s2_c_ge2;

  logic                sel_ready;
  logic                emit;
  logic [3:0]          pick;
  logic [3:0]          remaining;
  logic                s2_free;
  logic [3:0]          pending_in;
  logic                r1_in;
  logic                c1_in;

  dnmm_pkg::window_t   sel_vals_next;
  logic [ROW_W-1:0]    sel_row_next;
  logic [COL_W-1:0]    sel_col_next;

  assign r1_in = (s1_r != '0);
  assign c1_in = (s1_c != '0);

  // Results in order: upper-left, upper at row end, last-row left, last-row at row end
  assign pending_in = {s1_last_row && s1_row_end, s1_last_row && c1_in,
                       r1_in && s1_row_end, r1_in && c1_in};

  // Lowest pending result goes first
  always_comb begin
    if (pending[0]) begin
      pick = 4'b0001;
    end else if (pending[1]) begin
      pick = 4'b0010;
    end else if (pending[2]) begin
      pick = 4'b0100;
    end else begin
      pick = 4'b1000;
    end
  end

  assign remaining = pending & ~pick;
  assign emit      = (pending != '0) && sel_ready;
  assign s2_free   = (pending == '0) || (sel_ready && (remaining == '0));
  assign s1_adv    = s1_valid && s2_free;

  // Shift the window one column left and load the new column
  always_ff @(posedge clk) begin
    if (rst) begin
      window_regs <= '0;
    end else if (s1_adv) begin
      window_regs[0] <= window_regs[1];
      window_regs[1] <= window_regs[2];
      window_regs[2] <= s1_two_above;
      window_regs[3] <= window_regs[4];
      window_regs[4] <= window_regs[5];
      window_regs[5] <= s1_above;
      window_regs[6] <= window_regs[7];
      window_regs[7] <= window_regs[8];
      window_regs[8] <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s1_adv) begin
      pending <= pending_in;
    end else if (emit) begin
      pending <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_r     <= s1_r;
      s2_c     <= s1_c;
      s2_r_ge1 <= r1_in;
      s2_r_ge2 <= (s1_r > ROW_W'(1));
      s2_c_ge1 <= c1_in;
      s2_c_ge2 <= (s1_c > COL_W'(1));
    end
  end

  // Gather the clamped neighborhood of the picked result
  always_comb begin
    logic             cur_row;
    logic             cur_col;
    logic [1:0]       ri [3];
    logic [1:0]       ci [3];
    logic [3:0]       idx;
    cur_row = pick[2] || pick[3];
    cur_col = pick[1] || pick[3];
    ri[0] = cur_row ? (s2_r_ge1 ? 2'd1 : 2'd2) : (s2_r_ge2 ? 2'd0 : 2'd1);
    ri[1] = cur_row ? 2'd2 : 2'd1;
    ri[2] = 2'd2;
    ci[0] = cur_col ? (s2_c_ge1 ? 2'd1 : 2'd2) : (s2_c_ge2 ? 2'd0 : 2'd1);
    ci[1] = cur_col ? 2'd2 : 2'd1;
    ci[2] = 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        idx = 4'(ri[i]) * 4'd3 + 4'(ci[j]);
        sel_vals_next[i*3+j] = window_regs[idx];
      end
    end
    sel_row_next = cur_row ? s2_r : s2_r - ROW_W'(1);
    sel_col_next = cur_col ? s2_c : s2_c - COL_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: selected neighborhood register
  // ---------------------------------------------------------------------------
  logic                sel_valid;
  dnmm_pkg::window_t   sel_vals;
  logic [ROW_W-1:0]    sel_row;
  logic [COL_W-1:0]    sel_col;
  logic                sel_last;
  logic                out_ready;

  assign sel_ready = !sel_valid || out_ready;
  assign out_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (emit) begin
      sel_valid <= 1'b1;
    end else if (out_ready) begin
      sel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sel_vals <= sel_vals_next;
      sel_row  <= sel_row_next;
      sel_col  <= sel_col_next;
      sel_last <= (remaining == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Filter: mean by reciprocal multiply, median by row sort and median of three
  // ---------------------------------------------------------------------------
  dnmm_pkg::pixel_t filt_value;

  always_comb begin
    logic [dnmm_pkg::SUM_W-1:0]                    sum;
    logic [dnmm_pkg::SUM_W+dnmm_pkg::RECIP_W-1:0]  prod;
    dnmm_pkg::pixel_t                              lo [3];
    dnmm_pkg::pixel_t                              mid [3];
    dnmm_pkg::pixel_t                              hi [3];
    dnmm_pkg::pixel_t                              mean_val;
    dnmm_pkg::pixel_t                              median_val;
    sum = '0;
    for (int i = 0; i < dnmm_pkg::WIN_SIZE; i++) begin
      sum = sum + dnmm_pkg::SUM_W'(sel_vals[i]);
    end
    prod = (dnmm_pkg::SUM_W + dnmm_pkg::RECIP_W)'(sum) *
           (dnmm_pkg::SUM_W + dnmm_pkg::RECIP_W)'(dnmm_pkg::MEAN_RECIP);
    mean_val = prod[dnmm_pkg::MEAN_SHIFT +: PIX_W];

    for (int i = 0; i < 3; i++) begin
      lo[i]  = min2(min2(sel_vals[i*3], sel_vals[i*3+1]), sel_vals[i*3+2]);
      hi[i]  = max2(max2(sel_vals[i*3], sel_vals[i*3+1]), sel_vals[i*3+2]);
      mid[i] = med3(sel_vals[i*3], sel_vals[i*3+1], sel_vals[i*3+2]);
    end
    median_val = med3(max2(max2(lo[0], lo[1]), lo[2]),
                      med3(mid[0], mid[1], mid[2]),
                      min2(min2(hi[0], hi[1]), hi[2]));

    filt_value = (filter_mode == dnmm_pkg::MODE_MEDIAN) ? median_val : mean_val;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && sel_valid) begin
      m_axis_tdata <= {(dnmm_pkg::TDATA_W - PIX_W - ROW_W - COL_W)'(0),
                       sel_col, sel_row, filt_value};
      m_axis_tlast <= sel_last;
    end
  end

endmodule

// File: rtl/core/dnmm_ram.sv
`timescale 1ns / 1ps

module dnmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (read returns old data on a collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
